// ===== rtl/der_tlv_tokenizer_assert.svh =====
// ---------------------------------------------------------------------------
// DER TLV tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DER_TLV_TOKENIZER_ASSERT_SVH
`define DER_TLV_TOKENIZER_ASSERT_SVH

// condition must hold at every edge
`define DTT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dtt_pkg.sv =====
// ---------------------------------------------------------------------------
// DER TLV tokenizer package
// Token record, fault codes and sizes shared by the tokenizer modules.
// ---------------------------------------------------------------------------
package dtt_pkg;

	localparam int MaxNest = 32;
	localparam int LvlW    = $clog2(MaxNest + 1);
	localparam int AddrW   = $clog2(MaxNest);
	localparam int QDepth  = 4;
	localparam int QPtrW   = $clog2(QDepth);

	localparam logic [4:0] KIND_CLOSE = 5'd25;

	localparam logic [3:0] FLT_NONE      = 4'd0;
	localparam logic [3:0] FLT_TRUNC_TAG = 4'd1;
	localparam logic [3:0] FLT_TRUNC_HI  = 4'd2;
	localparam logic [3:0] FLT_HI_NONMIN = 4'd3;
	localparam logic [3:0] FLT_HI_BIG    = 4'd4;
	localparam logic [3:0] FLT_TRUNC_LEN = 4'd5;
	localparam logic [3:0] FLT_INDEF     = 4'd6;
	localparam logic [3:0] FLT_LEN_FF    = 4'd7;
	localparam logic [3:0] FLT_LEN_BIG   = 4'd8;
	localparam logic [3:0] FLT_TRUNC_LL  = 4'd9;
	localparam logic [3:0] FLT_LL_ZERO   = 4'd10;
	localparam logic [3:0] FLT_LL_SHORT  = 4'd11;
	localparam logic [3:0] FLT_DEEP      = 4'd12;
	localparam logic [3:0] FLT_OVER_BUF  = 4'd13;
	localparam logic [3:0] FLT_TRAIL     = 4'd14;

	typedef struct packed {
		logic [4:0]  kind;
		logic [1:0]  cls;
		logic        cons;
		logic [27:0] tag;
		logic [31:0] eoff;
		logic [31:0] coff;
		logic [31:0] len;
		logic [3:0]  fault;
		logic        done;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [31:0] fend;
		logic [1:0]  cls;
		logic [27:0] tag;
	} frame_t;

endpackage

// ===== rtl/dtt_front.sv =====
// ---------------------------------------------------------------------------
// DER TLV tokenizer front end
// Decodes identifier and length octets, keeps the nesting stack and emits
// tokens into the queue; close cascades run one pop per cycle while the queue has room.
// ---------------------------------------------------------------------------
`include "der_tlv_tokenizer_assert.svh"

module dtt_front
	import dtt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       byte_stall,
	output logic       push,
	output tok_t       push_tok,
	input  logic       full
);

	typedef enum logic {ST_BYTE, ST_CLOSE} st_t;
	typedef enum logic [2:0] {PH_IDENT, PH_TAGHI, PH_LEN0, PH_LENN, PH_CONTENT} ph_t;

	function automatic logic [4:0] open_kind(input logic [1:0] c, input logic [27:0] t);
		logic [4:0] k;
		k = 5'd2;
		if (c == 2'd0) begin
			if (t == 28'h10) k = 5'd0;
			else if (t == 28'h11) k = 5'd1;
		end else if (c == 2'd2) begin
			k = (t <= 28'd3) ? 5'd3 + 5'(t) : 5'd7;
		end
		return k;
	endfunction

	function automatic logic [4:0] prim_kind(input logic [1:0] c, input logic [27:0] t);
		logic [4:0] k;
		k = 5'd23;
		if (c == 2'd2) k = 5'd24;
		else if (c == 2'd0) begin
			case (t)
				28'h01: k = 5'd8;
				28'h02: k = 5'd9;
				28'h03: k = 5'd10;
				28'h04: k = 5'd11;
				28'h05: k = 5'd12;
				28'h06: k = 5'd13;
				28'h0A: k = 5'd14;
				28'h0C: k = 5'd15;
				28'h13: k = 5'd16;
				28'h14: k = 5'd17;
				28'h16: k = 5'd18;
				28'h17: k = 5'd19;
				28'h18: k = 5'd20;
				28'h1C: k = 5'd21;
				28'h1E: k = 5'd22;
				default: k = 5'd23;
			endcase
		end
		return k;
	endfunction

	st_t         st_q, st_d;
	ph_t         ph_q, ph_d, ph_n;
	logic [31:0] pos_q, pos_d;
	logic [27:0] tag_q, tag_d;
	logic [2:0]  tcnt_q, tcnt_d;
	logic [31:0] lacc_q, lacc_d, lacc_n;
	logic        lovf_q, lovf_d, lovf_n;
	logic [3:0]  left_q, left_d, ltot_q, ltot_d;
	logic        lz_q, lz_d, lz_n;
	logic [31:0] eoff_q, eoff_d;
	logic [1:0]  cls_q, cls_d;
	logic        cons_q, cons_d;
	logic [31:0] pend_q;
	tok_t        pnd_q, pnd_d;
	logic        pnd_v_q, pnd_v_d;
	frame_t      top_q, top_d;
	logic [LvlW-1:0] lvl_q, lvl_d, lvl_n;
	logic        fdone_q, fdone_d;
	logic [31:0] pend_d;
	logic [32:0] cl_p1_q, cl_p1_d;
	logic        cl_fin_q, cl_fin_d;

	frame_t      mem [MaxNest];
	frame_t      rd_q;
	logic        mem_we;
	logic [AddrW-1:0] wa, ra;
	logic [LvlW-1:0]  ra_full;

	logic        acc, close_hit, hdr_end, complete, tok_v;
	logic [3:0]  fault;
	logic [32:0] p1, parent, room;
	logic [31:0] len;
	tok_t        tok;

	assign byte_stall = (st_q != ST_BYTE) || full;
	assign acc        = byte_valid && !byte_stall;
	assign p1         = {1'b0, pos_q} + 33'd1;
	assign close_hit  = (lvl_q != '0) && ({1'b0, top_q.fend} == cl_p1_q);

	always_comb begin
		st_d = st_q; ph_d = ph_q; pos_d = pos_q; tag_d = tag_q; tcnt_d = tcnt_q;
		lacc_d = lacc_q; lovf_d = lovf_q; left_d = left_q; ltot_d = ltot_q; lz_d = lz_q;
		eoff_d = eoff_q; cls_d = cls_q; cons_d = cons_q; pend_d = pend_q;
		pnd_d = pnd_q; pnd_v_d = pnd_v_q; top_d = top_q; lvl_d = lvl_q;
		fdone_d = fdone_q; cl_p1_d = cl_p1_q; cl_fin_d = cl_fin_q;
		push = 1'b0; push_tok = '0; mem_we = 1'b0; wa = AddrW'(lvl_q - LvlW'(1));
		ph_n = ph_q; lvl_n = lvl_q; lacc_n = lacc_q; lovf_n = lovf_q; lz_n = lz_q;
		hdr_end = 1'b0; complete = 1'b0; tok_v = 1'b0; tok = '0; fault = FLT_NONE;
		len = '0; parent = '0; room = '0;

		if (st_q == ST_CLOSE) begin
			if (!full) begin
				if (close_hit) begin
					push     = pnd_v_q;
					push_tok = pnd_q;
					pnd_d    = '0;
					pnd_d.kind = KIND_CLOSE;
					pnd_d.cls  = top_q.cls;
					pnd_d.cons = 1'b1;
					pnd_d.tag  = top_q.tag;
					pnd_v_d  = 1'b1;
					lvl_d    = lvl_q - LvlW'(1);
					top_d    = rd_q;
				end else begin
					push_tok      = pnd_v_q ? pnd_q : '0;
					push_tok.last = 1'b1;
					pnd_v_d       = 1'b0;
					st_d          = ST_BYTE;
					if (lvl_q == '0) begin
						// top element finished
						push_tok.fault = cl_fin_q ? FLT_NONE : FLT_TRAIL;
						push_tok.done  = 1'b1;
						push           = pnd_v_q || !cl_fin_q;
						fdone_d        = 1'b1;
					end else begin
						// parent still open: only a buffer end faults here
						push_tok.fault = cl_fin_q ? FLT_OVER_BUF : FLT_NONE;
						push_tok.done  = cl_fin_q;
						push           = pnd_v_q || cl_fin_q;
					end
					if (cl_fin_q) begin
						pos_d = '0; ph_d = PH_IDENT; lvl_d = '0; fdone_d = 1'b0;
					end
				end
			end
		end else if (acc) begin
			pos_d = p1[31:0];
			if (fdone_q) begin
				if (final_byte) begin
					pos_d = '0; ph_d = PH_IDENT; lvl_d = '0; fdone_d = 1'b0;
				end
			end else begin
				unique case (ph_q)
					PH_IDENT: begin
						if (lvl_q >= LvlW'(MaxNest)) fault = FLT_DEEP;
						else begin
							eoff_d = pos_q;
							cls_d  = data_byte[7:6];
							cons_d = data_byte[5];
							tcnt_d = '0;
							if (data_byte[4:0] == 5'h1f) begin
								tag_d = '0; ph_n = PH_TAGHI;
							end else begin
								tag_d = {23'd0, data_byte[4:0]}; ph_n = PH_LEN0;
							end
						end
					end
					PH_TAGHI: begin
						if (tcnt_q == 3'd0 && data_byte == 8'h80) fault = FLT_HI_NONMIN;
						else if (tcnt_q >= 3'd4) fault = FLT_HI_BIG;
						else begin
							tcnt_d = tcnt_q + 3'd1;
							tag_d  = {tag_q[20:0], data_byte[6:0]};
							if (!data_byte[7]) ph_n = PH_LEN0;
						end
					end
					PH_LEN0: begin
						if (data_byte < 8'h80) begin
							len = {24'd0, data_byte}; lovf_n = 1'b0; hdr_end = 1'b1;
						end else if (data_byte == 8'h80) fault = FLT_INDEF;
						else if (data_byte == 8'hff) fault = FLT_LEN_FF;
						else if (data_byte[6:0] > 7'd8) fault = FLT_LEN_BIG;
						else begin
							ltot_d = data_byte[3:0];
							left_d = data_byte[3:0];
							lacc_d = '0;
							lovf_d = 1'b0;
							ph_n   = PH_LENN;
						end
					end
					PH_LENN: begin
						lovf_n = lovf_q || (lacc_q[31:24] != 8'd0);
						lacc_n = {lacc_q[23:0], data_byte};
						lz_n   = (left_q == ltot_q) ? (data_byte == 8'd0) : lz_q;
						lacc_d = lacc_n; lovf_d = lovf_n; lz_d = lz_n;
						left_d = left_q - 4'd1;
						if (left_q == 4'd1) begin
							if (lz_n) fault = FLT_LL_ZERO;
							else if (!lovf_n && lacc_n < 32'h80) fault = FLT_LL_SHORT;
							else begin
								len = lacc_n; hdr_end = 1'b1;
							end
						end
					end
					PH_CONTENT: begin
						if (p1 == {1'b0, pend_q}) complete = 1'b1;
					end
					default: ph_n = PH_IDENT;
				endcase

				if (hdr_end) begin
					parent = (lvl_q != '0) ? {1'b0, top_q.fend} : 33'h0_ffff_ffff;
					room   = parent - p1;
					if (p1 > parent || lovf_n || {1'b0, len} > room) fault = FLT_OVER_BUF;
					else begin
						tok_v     = 1'b1;
						tok.cls   = cls_q;
						tok.cons  = cons_q;
						tok.tag   = tag_q;
						tok.eoff  = eoff_q;
						tok.coff  = p1[31:0];
						tok.len   = len;
						if (cons_q) begin
							tok.kind  = open_kind(cls_q, tag_q);
							mem_we    = (lvl_q != '0);
							top_d     = {p1[31:0] + len, cls_q, tag_q};
							lvl_n     = lvl_q + LvlW'(1);
							ph_n      = PH_IDENT;
							complete  = (len == '0);
						end else begin
							tok.kind  = prim_kind(cls_q, tag_q);
							if (len == '0) complete = 1'b1;
							else begin
								pend_d = p1[31:0] + len;
								ph_n   = PH_CONTENT;
							end
						end
					end
				end

				lvl_d = lvl_n;
				ph_d  = ph_n;
				if (complete) begin
					st_d     = ST_CLOSE;
					ph_d     = PH_IDENT;
					pnd_d    = tok;
					pnd_v_d  = tok_v;
					cl_p1_d  = p1;
					cl_fin_d = final_byte;
				end else begin
					if (fault == FLT_NONE && final_byte) begin
						if (lvl_n != '0 || ph_n == PH_CONTENT) fault = FLT_OVER_BUF;
						else if (ph_n == PH_TAGHI) fault = FLT_TRUNC_HI;
						else if (ph_n == PH_LEN0) fault = FLT_TRUNC_LEN;
						else if (ph_n == PH_LENN) fault = FLT_TRUNC_LL;
						else fault = FLT_TRUNC_TAG;
					end
					push_tok       = tok;
					push_tok.fault = fault;
					push_tok.done  = (fault != FLT_NONE);
					push_tok.last  = 1'b1;
					push           = tok_v || (fault != FLT_NONE);
					if (fault != FLT_NONE) fdone_d = 1'b1;
					if (final_byte) begin
						pos_d = '0; ph_d = PH_IDENT; lvl_d = '0; fdone_d = 1'b0;
					end
				end
			end
		end
	end

	// entry just below the top, kept registered for the next pop
	assign ra_full = lvl_d - LvlW'(2);
	assign ra      = ra_full[AddrW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) mem[wa] <= top_q;
		rd_q <= (mem_we && wa == ra) ? top_q : mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_BYTE;
			ph_q    <= PH_IDENT;
			pos_q   <= '0;
			lvl_q   <= '0;
			fdone_q <= 1'b0;
			pnd_v_q <= 1'b0;
			tcnt_q  <= '0;
			left_q  <= '0;
		end else begin
			st_q    <= st_d;
			ph_q    <= ph_d;
			pos_q   <= pos_d;
			lvl_q   <= lvl_d;
			fdone_q <= fdone_d;
			pnd_v_q <= pnd_v_d;
			tcnt_q  <= tcnt_d;
			left_q  <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		tag_q    <= tag_d;
		lacc_q   <= lacc_d;
		lovf_q   <= lovf_d;
		ltot_q   <= ltot_d;
		lz_q     <= lz_d;
		eoff_q   <= eoff_d;
		cls_q    <= cls_d;
		cons_q   <= cons_d;
		pend_q   <= pend_d;
		pnd_q    <= pnd_d;
		top_q    <= top_d;
		cl_p1_q  <= cl_p1_d;
		cl_fin_q <= cl_fin_d;
	end

	`DTT_ASSERT(a_lvl_range, lvl_q <= LvlW'(MaxNest), "nesting level beyond stack depth")
	`DTT_ASSERT(a_no_push_full, !(push && full), "token pushed into a full queue")
	`DTT_ASSERT_NEXT(a_fin_clears, acc && final_byte && !complete, pos_q == '0 && lvl_q == '0, "no restart")
	`DTT_ASSERT(a_pend_last, !(pnd_v_q && pnd_q.last), "held token already marked last")

endmodule

// ===== rtl/dtt_queue.sv =====
// ---------------------------------------------------------------------------
// DER TLV tokenizer token queue
// Short register FIFO between the decoder and the output stage.
// ---------------------------------------------------------------------------
module dtt_queue
	import dtt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	output logic full,
	input  logic pop,
	output logic empty,
	output tok_t head
);

	tok_t             ent_q [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0]   cnt_q;

	assign full  = (cnt_q == (QPtrW+1)'(QDepth));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + QPtrW'(1);
			if (pop) rp_q <= rp_q + QPtrW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/dtt_back.sv =====
// ---------------------------------------------------------------------------
// DER TLV tokenizer output stage
// Output register fed from the queue head, held while the sink stalls.
// ---------------------------------------------------------------------------
module dtt_back
	import dtt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  tok_t head,
	output logic pop,
	output logic token_valid,
	input  logic token_stall,
	output tok_t out_tok
);

	logic vld_q;
	tok_t tok_q;

	assign pop         = !empty && (!vld_q || !token_stall);
	assign token_valid = vld_q;
	assign out_tok     = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || !token_stall) begin
			vld_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) tok_q <= head;
	end

endmodule

// ===== rtl/der_tlv_tokenizer.sv =====
// ---------------------------------------------------------------------------
// DER TLV tokenizer
// Streams DER bytes in and emits open, primitive and close tokens.
// ---------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  byte     | byte_valid   | byte_stall   | data_byte, final_byte
//  token    | token_valid  | token_stall  | token_kind .. run_last
//
//  One byte per cycle while the queue has room.
//  A byte that ends an element holds the byte channel until the close state ends;
//  the stack is popped one level per close token, one level a cycle while the queue has room.
//  arst_n clears all control state; the stack needs no clearing.
//  A stalled token channel fills the four-entry queue, then stalls bytes.
module der_tlv_tokenizer
	import dtt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [4:0]  token_kind,
	output logic [1:0]  id_class,
	output logic        is_constructed,
	output logic [27:0] tag_value,
	output logic [31:0] element_offset,
	output logic [31:0] content_offset,
	output logic [31:0] content_length,
	output logic [3:0]  fault_code,
	output logic        document_done,
	output logic        run_last
);

	logic push, full, pop, empty;
	tok_t push_tok, head, out_tok;

	dtt_front u_front (
		.clk, .arst_n, .byte_valid, .data_byte, .final_byte, .byte_stall,
		.push, .push_tok, .full
	);

	dtt_queue u_queue (
		.clk, .arst_n, .push, .push_tok, .full, .pop, .empty, .head
	);

	dtt_back u_back (
		.clk, .arst_n, .empty, .head, .pop, .token_valid, .token_stall, .out_tok
	);

	assign token_kind     = out_tok.kind;
	assign id_class       = out_tok.cls;
	assign is_constructed = out_tok.cons;
	assign tag_value      = out_tok.tag;
	assign element_offset = out_tok.eoff;
	assign content_offset = out_tok.coff;
	assign content_length = out_tok.len;
	assign fault_code     = out_tok.fault;
	assign document_done  = out_tok.done;
	assign run_last       = out_tok.last;

endmodule
